// ===== rtl/pid3_pkg.sv =====
package pid3_pkg;

    localparam int POS_W   = 16;
    localparam int ERR_W   = POS_W + 1;
    localparam int DERR_W  = POS_W + 2;
    localparam int GAIN_W  = 16;
    localparam int VEL_W   = 16;
    localparam int LIM_W   = 15;
    localparam int MS_W    = 16;
    localparam int INTEG_W = 40;
    localparam int PROD_W  = 56;
    localparam int QUO_W   = 44;
    localparam int SUM_W   = 36;
    localparam int CNT_W   = 6;
    localparam int FRAC_SH = 12;

    localparam logic [CNT_W-1:0]  MUL_STEPS = CNT_W'(GAIN_W);
    localparam logic [CNT_W-1:0]  DIV_STEPS = CNT_W'(QUO_W);
    localparam logic [GAIN_W-1:0] MS_PER_S  = GAIN_W'(1000);
    localparam logic signed [INTEG_W:0] INTEG_LIM = 41'sh7F_FFFF_FFFF;

    localparam int CFG_AW = 5;

    typedef enum logic [2:0] {
        REG_KP_XY   = 3'd0,
        REG_KI_XY   = 3'd1,
        REG_KD_XY   = 3'd2,
        REG_KP_VERT = 3'd3,
        REG_KI_VERT = 3'd4,
        REG_KD_VERT = 3'd5,
        REG_MAX_VEL = 3'd6,
        REG_ARRIVE  = 3'd7
    } reg_idx_t;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } pid3_req_t;

endpackage

// ===== rtl/pid3_if.sv =====
interface pid3_in_if;
    logic               valid;
    logic               ready;
    logic               run;
    logic [15:0]        elapsed_ms;
    logic               detected;
    logic signed [15:0] meas_x;
    logic signed [15:0] meas_y;
    logic signed [15:0] meas_z;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] target_z;

    modport source (output valid, run, elapsed_ms, detected, meas_x, meas_y, meas_z,
                    target_x, target_y, target_z, input ready);
    modport sink (input valid, run, elapsed_ms, detected, meas_x, meas_y, meas_z,
                  target_x, target_y, target_z, output ready);
endinterface

interface pid3_out_if;
    logic               valid;
    logic               ready;
    logic               cmd_valid;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic               arrived;

    modport source (output valid, cmd_valid, vel_x, vel_y, vel_z, arrived, input ready);
    modport sink (input valid, cmd_valid, vel_x, vel_y, vel_z, arrived, output ready);
endinterface

// ===== rtl/pid3_serial.sv =====
// Shared bit-serial unit: shift-add multiply (one multiplier bit per cycle)
// and restoring divide (one quotient bit per cycle). Operands are magnitudes.
module pid3_serial
    import pid3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  pid3_req_t         req,
    input  logic [PROD_W-1:0] opa,
    input  logic [GAIN_W-1:0] opb,
    output logic              done,
    output logic [PROD_W-1:0] res
);

    logic              busy_reg;
    logic              done_reg;
    op_t               op_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PROD_W-1:0] a_reg;
    logic [GAIN_W-1:0] b_reg;
    logic [PROD_W-1:0] r_reg;

    logic [GAIN_W:0]   rem_sh;
    logic [GAIN_W:0]   rem_sub;
    logic              fits;

    assign rem_sh  = {r_reg[GAIN_W-1:0], a_reg[QUO_W-1]};
    assign fits    = rem_sh >= {1'b0, b_reg};
    assign rem_sub = rem_sh - {1'b0, b_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !req.start && busy_reg && (cnt_reg == '0);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= (req.op == OP_MUL) ? MUL_STEPS - 1'b1 : DIV_STEPS - 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= opa;
            b_reg <= opb;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                OP_MUL:
                begin
                    if (b_reg[0])
                        r_reg <= r_reg + a_reg;
                    a_reg <= {a_reg[PROD_W-2:0], 1'b0};
                    b_reg <= {1'b0, b_reg[GAIN_W-1:1]};
                end
                OP_DIV:
                begin
                    r_reg <= {{(PROD_W-GAIN_W){1'b0}},
                              fits ? rem_sub[GAIN_W-1:0] : rem_sh[GAIN_W-1:0]};
                    a_reg <= {a_reg[PROD_W-2:0], fits};
                end
            endcase
        end
    end

    assign done = done_reg;
    assign res  = (op_reg == OP_MUL) ? r_reg : {{(PROD_W-QUO_W){1'b0}}, a_reg[QUO_W-1:0]};

endmodule

// ===== rtl/three_axis_position_pid_unit.sv =====
// Three-axis position PID. One command per accepted tick. A stopped tick or a
// running tick without a fresh pose goes from ST_START straight to ST_FIN. A
// tick with a fresh pose runs the three axes in turn through one shared
// bit-serial multiply/divide unit; the derivative path is skipped when
// elapsed_ms is zero. A new tick is taken as soon as the sequencer is idle,
// even while the previous command still waits on out_ch.
// Gains are unsigned Q4.12, positions and velocities signed Q8.8; the APB
// registers sit at byte offsets 4*index.
module three_axis_position_pid_unit
    import pid3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    pid3_in_if.sink           in_ch,
    pid3_out_if.source        out_ch
);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_START = 12'b0000_0000_0010,
        ST_AX_E  = 12'b0000_0000_0100,
        ST_W_MI  = 12'b0000_0000_1000,
        ST_W_MP  = 12'b0000_0001_0000,
        ST_W_MK  = 12'b0000_0010_0000,
        ST_W_DI  = 12'b0000_0100_0000,
        ST_W_MD  = 12'b0000_1000_0000,
        ST_W_MT  = 12'b0001_0000_0000,
        ST_W_DD  = 12'b0010_0000_0000,
        ST_AX_END = 12'b0100_0000_0000,
        ST_FIN   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;

    logic [GAIN_W-1:0] kp_xy_reg, ki_xy_reg, kd_xy_reg;
    logic [GAIN_W-1:0] kp_vert_reg, ki_vert_reg, kd_vert_reg;
    logic [LIM_W-1:0]  max_vel_reg, arrive_reg;

    logic                      run_reg, det_reg, prev_run_reg;
    logic [MS_W-1:0]           ms_reg;
    logic signed [POS_W-1:0]   tgt_reg   [3];
    logic signed [POS_W-1:0]   held_reg  [3];
    logic signed [ERR_W-1:0]   prev_reg  [3];
    logic signed [INTEG_W-1:0] integ_reg [3];
    logic signed [VEL_W-1:0]   vel_reg   [3];

    logic [1:0]                ax_reg;
    logic signed [ERR_W-1:0]   e_reg;
    logic [ERR_W-1:0]          emag_reg;
    logic                      esign_reg;
    logic [DERR_W-1:0]         demag_reg;
    logic                      design_reg;
    logic signed [INTEG_W-1:0] acc_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic                      arr_ok_reg;
    logic                      res_valid_reg, res_arr_reg;

    logic                      out_valid_reg, out_cmd_reg, out_arr_reg;
    logic signed [VEL_W-1:0]   out_vel_reg [3];

    // serial unit hookup
    pid3_req_t         req;
    logic [PROD_W-1:0] opa;
    logic [GAIN_W-1:0] opb;
    logic              unit_done;
    logic [PROD_W-1:0] unit_res;

    pid3_serial u_serial (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .opa   (opa),
        .opb   (opb),
        .done  (unit_done),
        .res   (unit_res)
    );

    // configuration port
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_xy_reg   <= GAIN_W'(41);
            ki_xy_reg   <= GAIN_W'(41);
            kd_xy_reg   <= GAIN_W'(41);
            kp_vert_reg <= GAIN_W'(41);
            ki_vert_reg <= GAIN_W'(41);
            kd_vert_reg <= GAIN_W'(41);
            max_vel_reg <= LIM_W'(256);
            arrive_reg  <= LIM_W'(26);
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx_t'(paddr[4:2]))
                REG_KP_XY:   kp_xy_reg   <= pwdata[GAIN_W-1:0];
                REG_KI_XY:   ki_xy_reg   <= pwdata[GAIN_W-1:0];
                REG_KD_XY:   kd_xy_reg   <= pwdata[GAIN_W-1:0];
                REG_KP_VERT: kp_vert_reg <= pwdata[GAIN_W-1:0];
                REG_KI_VERT: ki_vert_reg <= pwdata[GAIN_W-1:0];
                REG_KD_VERT: kd_vert_reg <= pwdata[GAIN_W-1:0];
                REG_MAX_VEL: max_vel_reg <= pwdata[LIM_W-1:0];
                REG_ARRIVE:  arrive_reg  <= pwdata[LIM_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[4:2]))
            REG_KP_XY:   prdata = {16'b0, kp_xy_reg};
            REG_KI_XY:   prdata = {16'b0, ki_xy_reg};
            REG_KD_XY:   prdata = {16'b0, kd_xy_reg};
            REG_KP_VERT: prdata = {16'b0, kp_vert_reg};
            REG_KI_VERT: prdata = {16'b0, ki_vert_reg};
            REG_KD_VERT: prdata = {16'b0, kd_vert_reg};
            REG_MAX_VEL: prdata = {17'b0, max_vel_reg};
            REG_ARRIVE:  prdata = {17'b0, arrive_reg};
        endcase
    end

    // per-axis selection
    logic                    in_fire, out_free, is_z, ms_zero;
    logic signed [ERR_W-1:0]  err_now;
    logic signed [DERR_W-1:0] de_now;
    logic [ERR_W-1:0]        emag_now;
    logic [DERR_W-1:0]       demag_now;
    logic [GAIN_W-1:0]       kp_sel, ki_sel, kd_sel;
    logic signed [ERR_W-1:0] err_all [3];
    logic [INTEG_W-1:0]      acc_mag;
    logic signed [INTEG_W:0] term41, isum, isat;
    logic signed [SUM_W-1:0] p_term, q_term, v_raw, v_lim, mv_pos;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign is_z     = (ax_reg == 2'd2);
    assign ms_zero  = (ms_reg == '0);
    assign kp_sel   = is_z ? kp_vert_reg : kp_xy_reg;
    assign ki_sel   = is_z ? ki_vert_reg : ki_xy_reg;
    assign kd_sel   = is_z ? kd_vert_reg : kd_xy_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            err_all[i] = ERR_W'(held_reg[i]) - ERR_W'(tgt_reg[i]);
    end

    assign err_now   = ERR_W'(held_reg[ax_reg]) - ERR_W'(tgt_reg[ax_reg]);
    assign de_now    = DERR_W'(err_now) - DERR_W'(prev_reg[ax_reg]);
    assign emag_now  = err_now[ERR_W-1] ? ERR_W'(-err_now) : ERR_W'(err_now);
    assign demag_now = de_now[DERR_W-1] ? DERR_W'(-de_now) : DERR_W'(de_now);
    assign acc_mag   = acc_reg[INTEG_W-1] ? INTEG_W'(-acc_reg) : INTEG_W'(acc_reg);

    // integrator update with saturation
    assign term41 = $signed({8'b0, unit_res[32:0]});
    assign isum   = $signed({integ_reg[ax_reg][INTEG_W-1], integ_reg[ax_reg]})
                    + (esign_reg ? -term41 : term41);
    always_comb
    begin
        if (isum > INTEG_LIM)
            isat = INTEG_LIM;
        else if (isum < -INTEG_LIM)
            isat = -INTEG_LIM;
        else
            isat = isum;
    end

    assign p_term = $signed({15'b0, unit_res[32:FRAC_SH]});
    assign q_term = $signed({1'b0, unit_res[34:0]});

    // output of this axis: negate x, clamp
    assign mv_pos = $signed({21'b0, max_vel_reg});
    assign v_raw  = (ax_reg == 2'd0) ? -sum_reg : sum_reg;
    always_comb
    begin
        if (v_raw > mv_pos)
            v_lim = mv_pos;
        else if (v_raw < -mv_pos)
            v_lim = -mv_pos;
        else
            v_lim = v_raw;
    end

    // launches into the serial unit
    always_comb
    begin
        req.start = 1'b0;
        req.op    = OP_MUL;
        opa       = '0;
        opb       = '0;
        unique case (state_reg)
            ST_AX_E:
            begin
                req.start = 1'b1;
                opa       = {{(PROD_W-ERR_W){1'b0}}, emag_now};
                opb       = ms_reg;
            end
            ST_W_MI:
            begin
                req.start = unit_done;
                opa       = {{(PROD_W-ERR_W){1'b0}}, emag_reg};
                opb       = kp_sel;
            end
            ST_W_MP:
            begin
                req.start = unit_done;
                opa       = {{(PROD_W-INTEG_W){1'b0}}, acc_mag};
                opb       = ki_sel;
            end
            ST_W_MK:
            begin
                req.start = unit_done;
                req.op    = OP_DIV;
                opa       = {{FRAC_SH{1'b0}}, unit_res[PROD_W-1:FRAC_SH]};
                opb       = MS_PER_S;
            end
            ST_W_DI:
            begin
                req.start = unit_done && !ms_zero;
                opa       = {{(PROD_W-DERR_W){1'b0}}, demag_reg};
                opb       = kd_sel;
            end
            ST_W_MD:
            begin
                req.start = unit_done;
                opa       = {{(PROD_W-INTEG_W){1'b0}}, unit_res[INTEG_W-1:0]};
                opb       = MS_PER_S;
            end
            ST_W_MT:
            begin
                req.start = unit_done;
                req.op    = OP_DIV;
                opa       = {{FRAC_SH{1'b0}}, unit_res[PROD_W-1:FRAC_SH]};
                opb       = ms_reg;
            end
            default:
            begin
                req.start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_run_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ax_reg        <= 2'd0;
            for (int i = 0; i < 3; i++)
            begin
                held_reg[i]  <= '0;
                prev_reg[i]  <= '0;
                integ_reg[i] <= '0;
            end
        end
        else
        begin
            if ((state_reg == ST_FIN) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (in_ch.detected)
                        begin
                            held_reg[0] <= in_ch.meas_x;
                            held_reg[1] <= in_ch.meas_y;
                            held_reg[2] <= in_ch.meas_z;
                        end
                        state_reg <= ST_START;
                    end
                end
                ST_START:
                begin
                    ax_reg       <= 2'd0;
                    prev_run_reg <= run_reg;
                    if (!run_reg)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            prev_reg[i]  <= '0;
                            integ_reg[i] <= '0;
                        end
                        state_reg <= ST_FIN;
                    end
                    else if (!det_reg)
                    begin
                        for (int i = 0; i < 3; i++)
                            prev_reg[i] <= err_all[i];
                        state_reg <= ST_FIN;
                    end
                    else
                        state_reg <= ST_AX_E;
                end
                ST_AX_E:   state_reg <= ST_W_MI;
                ST_W_MI:
                begin
                    if (unit_done)
                    begin
                        integ_reg[ax_reg] <= isat[INTEG_W-1:0];
                        state_reg         <= ST_W_MP;
                    end
                end
                ST_W_MP:   if (unit_done) state_reg <= ST_W_MK;
                ST_W_MK:   if (unit_done) state_reg <= ST_W_DI;
                ST_W_DI:
                begin
                    if (unit_done)
                        state_reg <= ms_zero ? ST_AX_END : ST_W_MD;
                end
                ST_W_MD:   if (unit_done) state_reg <= ST_W_MT;
                ST_W_MT:   if (unit_done) state_reg <= ST_W_DD;
                ST_W_DD:   if (unit_done) state_reg <= ST_AX_END;
                ST_AX_END:
                begin
                    prev_reg[ax_reg] <= e_reg;
                    if (is_z)
                        state_reg <= ST_FIN;
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= ST_AX_E;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    run_reg    <= in_ch.run;
                    det_reg    <= in_ch.detected;
                    ms_reg     <= in_ch.elapsed_ms;
                    tgt_reg[0] <= in_ch.target_x;
                    tgt_reg[1] <= in_ch.target_y;
                    tgt_reg[2] <= in_ch.target_z;
                end
            end
            ST_START:
            begin
                res_valid_reg <= run_reg || prev_run_reg;
                res_arr_reg   <= 1'b0;
                arr_ok_reg    <= 1'b1;
                for (int i = 0; i < 3; i++)
                    vel_reg[i] <= '0;
            end
            ST_AX_E:
            begin
                e_reg      <= err_now;
                emag_reg   <= emag_now;
                esign_reg  <= err_now[ERR_W-1];
                demag_reg  <= demag_now;
                design_reg <= de_now[DERR_W-1];
                arr_ok_reg <= arr_ok_reg && (emag_now < {2'b0, arrive_reg});
            end
            ST_W_MI:
            begin
                if (unit_done)
                    acc_reg <= isat[INTEG_W-1:0];
            end
            ST_W_MP:
            begin
                if (unit_done)
                    sum_reg <= esign_reg ? -p_term : p_term;
            end
            ST_W_DI:
            begin
                if (unit_done)
                    sum_reg <= acc_reg[INTEG_W-1] ? sum_reg - q_term : sum_reg + q_term;
            end
            ST_W_DD:
            begin
                if (unit_done)
                    sum_reg <= design_reg ? sum_reg - q_term : sum_reg + q_term;
            end
            ST_AX_END:
            begin
                vel_reg[ax_reg] <= v_lim[VEL_W-1:0];
                if (is_z)
                    res_arr_reg <= arr_ok_reg;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_cmd_reg <= res_valid_reg;
                    out_arr_reg <= res_arr_reg;
                    for (int i = 0; i < 3; i++)
                        out_vel_reg[i] <= res_arr_reg ? '0 : vel_reg[i];
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign in_ch.ready      = (state_reg == ST_IDLE);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.cmd_valid = out_cmd_reg;
    assign out_ch.arrived   = out_arr_reg;
    assign out_ch.vel_x     = out_vel_reg[0];
    assign out_ch.vel_y     = out_vel_reg[1];
    assign out_ch.vel_z     = out_vel_reg[2];

`ifndef ASSERT_OFF
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        unit_done |-> (state_reg == ST_W_MI) || (state_reg == ST_W_MP) ||
                      (state_reg == ST_W_MK) || (state_reg == ST_W_DI) ||
                      (state_reg == ST_W_MD) || (state_reg == ST_W_MT) ||
                      (state_reg == ST_W_DD))
        else $error("serial unit finished outside a wait state");

    a_arrived_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_arr_reg |-> out_cmd_reg && out_vel_reg[0] == '0 &&
                                         out_vel_reg[1] == '0 && out_vel_reg[2] == '0)
        else $error("arrived command carries nonzero velocity");

    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !in_ch.run |-> ##2 integ_reg[0] == '0 && integ_reg[1] == '0 &&
                                      integ_reg[2] == '0 && !prev_run_reg)
        else $error("stopped tick did not clear integrators");
`endif

endmodule

// ===== bench/pid3_checker.sv =====
module pid3_checker
    import pid3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    pid3_in_if                in_ch,
    pid3_out_if               out_ch,
    output int                fails,
    output int                pending,
    output int                n_cmds,
    output int                n_arrived
);

    localparam longint INTEG_SAT = 64'sd549755813887;

    typedef struct {
        logic        run;
        logic [15:0] ms;
        logic        det;
        logic signed [15:0] meas [3];
        logic signed [15:0] tgt [3];
    } tick_t;

    typedef struct packed {
        logic               cmd_valid;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] vel_z;
        logic               arrived;
    } cmd_t;

    // model state and register copies
    logic [GAIN_W-1:0] kp_xy, ki_xy, kd_xy, kp_z, ki_z, kd_z;
    logic [LIM_W-1:0]  vel_lim, arrive_lim;
    longint            pose [3];
    longint            last_err [3];
    longint            integ [3];
    logic              was_running;

    cmd_t cmd_q [$];

    function automatic longint axis_velocity(int a, longint e, longint ms,
                                             logic [15:0] kp, logic [15:0] ki,
                                             logic [15:0] kd);
        longint acc, p, i_term, d, v, lim;
        acc = integ[a] + e * ms;
        if (acc > INTEG_SAT) acc = INTEG_SAT;
        if (acc < -INTEG_SAT) acc = -INTEG_SAT;
        integ[a] = acc;
        p = (longint'(kp) * e) / 4096;
        i_term = (longint'(ki) * acc) / (64'sd4096 * 1000);
        d = 0;
        if (ms != 0)
            d = (longint'(kd) * (e - last_err[a]) * 1000) / (64'sd4096 * ms);
        v = p + i_term + d;
        if (a == 0) v = -v;
        lim = longint'(vel_lim);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v;
    endfunction

    function automatic cmd_t predict_command(tick_t t);
        cmd_t   r;
        longint err [3];
        longint vel [3];
        longint mag;
        r = '0;
        vel = '{0, 0, 0};
        if (t.det)
            for (int i = 0; i < 3; i++) pose[i] = longint'(t.meas[i]);
        if (!t.run) begin
            for (int i = 0; i < 3; i++)
            begin
                last_err[i] = 0;
                integ[i] = 0;
            end
            r.cmd_valid = was_running;
        end
        else begin
            r.cmd_valid = 1'b1;
            for (int i = 0; i < 3; i++) err[i] = pose[i] - longint'(t.tgt[i]);
            if (t.det) begin
                vel[0] = axis_velocity(0, err[0], longint'(t.ms), kp_xy, ki_xy, kd_xy);
                vel[1] = axis_velocity(1, err[1], longint'(t.ms), kp_xy, ki_xy, kd_xy);
                vel[2] = axis_velocity(2, err[2], longint'(t.ms), kp_z, ki_z, kd_z);
                r.arrived = 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    mag = err[i] < 0 ? -err[i] : err[i];
                    if (mag >= longint'(arrive_lim)) r.arrived = 1'b0;
                end
                if (r.arrived) vel = '{0, 0, 0};
            end
            for (int i = 0; i < 3; i++) last_err[i] = err[i];
        end
        was_running = t.run;
        r.vel_x = vel[0][15:0];
        r.vel_y = vel[1][15:0];
        r.vel_z = vel[2][15:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tick_t t;
        cmd_t  want;
        if (!rst_n) begin
            {kp_xy, ki_xy, kd_xy, kp_z, ki_z, kd_z} = {6{16'd41}};
            vel_lim = 15'd256;
            arrive_lim = 15'd26;
            pose = '{0, 0, 0};
            last_err = '{0, 0, 0};
            integ = '{0, 0, 0};
            was_running = 1'b0;
            cmd_q.delete();
            fails = 0;
            n_cmds = 0;
            n_arrived = 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_KP_XY:   kp_xy = pwdata[15:0];
                    REG_KI_XY:   ki_xy = pwdata[15:0];
                    REG_KD_XY:   kd_xy = pwdata[15:0];
                    REG_KP_VERT: kp_z = pwdata[15:0];
                    REG_KI_VERT: ki_z = pwdata[15:0];
                    REG_KD_VERT: kd_z = pwdata[15:0];
                    REG_MAX_VEL: vel_lim = pwdata[14:0];
                    REG_ARRIVE:  arrive_lim = pwdata[14:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                t.run = in_ch.run;
                t.ms = in_ch.elapsed_ms;
                t.det = in_ch.detected;
                t.meas = '{in_ch.meas_x, in_ch.meas_y, in_ch.meas_z};
                t.tgt = '{in_ch.target_x, in_ch.target_y, in_ch.target_z};
                cmd_q.push_back(predict_command(t));
            end
            if (out_ch.valid && out_ch.ready) begin
                n_cmds++;
                if (out_ch.arrived) n_arrived++;
                if (cmd_q.size() == 0) begin
                    $error("command transfer with no tick outstanding");
                    fails++;
                end
                else begin
                    want = cmd_q.pop_front();
                    if (out_ch.cmd_valid !== want.cmd_valid) begin
                        $error("cmd_valid: expected %0d got %0d", want.cmd_valid,
                               out_ch.cmd_valid);
                        fails++;
                    end
                    if (out_ch.vel_x !== want.vel_x) begin
                        $error("vel_x: expected %0d got %0d", want.vel_x, out_ch.vel_x);
                        fails++;
                    end
                    if (out_ch.vel_y !== want.vel_y) begin
                        $error("vel_y: expected %0d got %0d", want.vel_y, out_ch.vel_y);
                        fails++;
                    end
                    if (out_ch.vel_z !== want.vel_z) begin
                        $error("vel_z: expected %0d got %0d", want.vel_z, out_ch.vel_z);
                        fails++;
                    end
                    if (out_ch.arrived !== want.arrived) begin
                        $error("arrived: expected %0d got %0d", want.arrived,
                               out_ch.arrived);
                        fails++;
                    end
                end
            end
        end
        pending = cmd_q.size();
    end

endmodule

// ===== bench/tb_three_axis_position_pid_unit.sv =====
module tb_three_axis_position_pid_unit;
    import pid3_pkg::*;

    localparam int CYCLE_LIMIT = 8000000;
    localparam int RAND_PHASES = 7;
    localparam int PHASE_TICKS = 250;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int fails, pending, n_cmds, n_arrived;
    int cycles;
    int n_ticks;
    bit no_idle;
    bit hold_req;

    pid3_in_if  in_ch ();
    pid3_out_if out_ch ();

    three_axis_position_pid_unit dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_ch(in_ch), .out_ch(out_ch)
    );

    pid3_checker chk (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .pready(pready), .in_ch(in_ch),
        .out_ch(out_ch), .fails(fails), .pending(pending), .n_cmds(n_cmds),
        .n_arrived(n_arrived)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("FAIL three_axis_position_pid_unit");
                $finish;
            end
        end
    end

    // command receiver; a requested hold keeps ready low for a long stretch
    initial
    begin
        int held;
        bit hold_done;
        hold_done = 1'b0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                out_ch.ready = 1'b0;
                for (held = 0; held < 4000; held++) @(negedge clk);
                hold_done = 1'b1;
            end
            out_ch.ready = no_idle || ($urandom_range(99) >= 36);
        end
    end

    task automatic reg_write(reg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = CFG_AW'({idx, 2'b00});
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic send_tick(logic run, logic [15:0] ms, logic det,
                             logic [15:0] mx, logic [15:0] my, logic [15:0] mz,
                             logic [15:0] tx, logic [15:0] ty, logic [15:0] tz);
        int gap;
        if (!no_idle && $urandom_range(99) < 36) begin
            in_ch.valid = 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.run = run;
        in_ch.elapsed_ms = ms;
        in_ch.detected = det;
        in_ch.meas_x = mx;
        in_ch.meas_y = my;
        in_ch.meas_z = mz;
        in_ch.target_x = tx;
        in_ch.target_y = ty;
        in_ch.target_z = tz;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
        n_ticks++;
    endtask

    task automatic drain;
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic logic [15:0] near(logic [15:0] base, int spread);
        return base + 16'($urandom_range(2 * spread) - spread);
    endfunction

    task automatic random_tick;
        logic [15:0] mx, my, mz, ms;
        int kind;
        int spread;
        kind = $urandom_range(99);
        mx = 16'($urandom);
        my = 16'($urandom);
        mz = 16'($urandom);
        ms = $urandom_range(99) < 80 ? 16'($urandom_range(200)) : 16'($urandom);
        spread = $urandom_range(1) ? 40 : 2000;
        if (kind < 8)
            send_tick(1'b0, 16'($urandom), 1'($urandom), mx, my, mz, 16'($urandom),
                      16'($urandom), 16'($urandom));
        else if (kind < 15)
            send_tick(1'b1, ms, 1'b0, mx, my, mz, near(mx, spread), near(my, spread),
                      near(mz, spread));
        else if (kind < 25)
            send_tick(1'($urandom), 16'($urandom), 1'($urandom), mx, my, mz,
                      16'($urandom), 16'($urandom), 16'($urandom));
        else
            send_tick(1'b1, ms, 1'b1, mx, my, mz, near(mx, spread), near(my, spread),
                      near(mz, spread));
    endtask

    initial
    begin
        logic [31:0] lim;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.run = 1'b0;
        in_ch.elapsed_ms = '0;
        in_ch.detected = 1'b0;
        in_ch.meas_x = '0;
        in_ch.meas_y = '0;
        in_ch.meas_z = '0;
        in_ch.target_x = '0;
        in_ch.target_y = '0;
        in_ch.target_z = '0;
        n_ticks = 0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed ticks at reset gains
        send_tick(1'b0, 16'd100, 1'b0, '0, '0, '0, '0, '0, '0);
        send_tick(1'b1, 16'd100, 1'b0, '0, '0, '0, 16'h0100, 16'h0200, 16'h0300);
        send_tick(1'b1, 16'd100, 1'b1, 16'h0010, 16'h0020, 16'h0030, 16'h0010, 16'h0020,
                  16'h0030);
        send_tick(1'b1, 16'd100, 1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                  16'h7FFF);
        send_tick(1'b1, 16'hFFFF, 1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000,
                  16'h8000, 16'h8000);
        send_tick(1'b1, 16'd0, 1'b1, 16'h0400, 16'hFC00, 16'h0100, '0, '0, '0);
        send_tick(1'b1, 16'd1, 1'b1, 16'hFC00, 16'h0400, 16'hFF00, '0, '0, '0);
        send_tick(1'b1, 16'd50, 1'b0, 16'h1234, 16'h1234, 16'h1234, 16'h0100, '0, '0);
        send_tick(1'b0, 16'd50, 1'b0, '0, '0, '0, '0, '0, '0);
        send_tick(1'b0, 16'd50, 1'b1, 16'h0300, 16'h0200, 16'h0100, '0, '0, '0);
        send_tick(1'b1, 16'd20, 1'b0, '0, '0, '0, 16'h0300, 16'h0200, 16'h0100);
        send_tick(1'b1, 16'd20, 1'b1, 16'h0300, 16'h0200, 16'h0100, 16'h0319, 16'h01E7,
                  16'h0100);
        send_tick(1'b1, 16'd20, 1'b1, 16'h0300, 16'h0200, 16'h0100, 16'h031A, 16'h0200,
                  16'h0100);
        send_tick(1'b0, 16'd0, 1'b0, '0, '0, '0, '0, '0, '0);
        drain();

        // extreme gains, zero clamp then full clamp
        reg_write(REG_KP_XY, 32'hFFFF);
        reg_write(REG_KI_XY, 32'hFFFF);
        reg_write(REG_KD_XY, 32'hFFFF);
        reg_write(REG_KP_VERT, 32'h0);
        reg_write(REG_KI_VERT, 32'hFFFF);
        reg_write(REG_KD_VERT, 32'h0);
        reg_write(REG_MAX_VEL, 32'h0);
        reg_write(REG_ARRIVE, 32'h0);
        send_tick(1'b1, 16'd10, 1'b1, 16'h1000, 16'hF000, 16'h0800, '0, '0, '0);
        send_tick(1'b1, 16'd10, 1'b1, '0, '0, '0, '0, '0, '0);
        drain();
        reg_write(REG_MAX_VEL, 32'h7FFF);
        reg_write(REG_ARRIVE, 32'h7FFF);
        send_tick(1'b1, 16'hFFFF, 1'b1, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                  16'h8000);
        send_tick(1'b1, 16'hFFFF, 1'b1, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                  16'h8000);
        send_tick(1'b1, 16'd1, 1'b1, 16'h0100, 16'h0100, 16'h0100, '0, '0, '0);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            lim = (ph % 3 == 0) ? 32'h7FFF : 32'($urandom_range(2000));
            reg_write(REG_KP_XY, ph == 1 ? 32'h0 : $urandom);
            reg_write(REG_KI_XY, $urandom_range(8192));
            reg_write(REG_KD_XY, $urandom);
            reg_write(REG_KP_VERT, ph == 2 ? 32'hFFFF : $urandom);
            reg_write(REG_KI_VERT, $urandom);
            reg_write(REG_KD_VERT, $urandom_range(8192));
            reg_write(REG_MAX_VEL, ph == 4 ? 32'h0 : lim);
            reg_write(REG_ARRIVE, ph == 5 ? 32'h7FFF : 32'($urandom_range(80)));
            no_idle = (ph == 3);
            for (int k = 0; k < PHASE_TICKS; k++)
            begin
                if (ph == 1 && k == 20) hold_req = 1'b1;
                random_tick();
            end
            drain();
        end

        repeat (600) @(posedge clk);
        $display("%0d ticks in, %0d commands out, %0d arrivals, over %0d gain settings",
                 n_ticks, n_cmds, n_arrived, RAND_PHASES + 3);
        $display("stopped, coasting, falling-run, zero-dt and clamp cases included");
        if (fails == 0 && pending == 0)
            $display("PASS three_axis_position_pid_unit");
        else
            $display("FAIL three_axis_position_pid_unit");
        $finish;
    end

endmodule
